>>> rtl/tlpq_pkg.sv
// ----------------------------------------------------------------------------
// tlpq_pkg
// Shared constants and codes for the three-level priority queue.
// ----------------------------------------------------------------------------
package tlpq_pkg;

  localparam int NUM_LEVELS        = 3;
  localparam int LEVEL_DEPTH_DEF   = 16;
  localparam int DATA_W            = 32;
  localparam int PADDR_W           = 3;

  localparam logic signed [DATA_W-1:0] LOWER_RESET = 32'sd50;
  localparam logic signed [DATA_W-1:0] UPPER_RESET = 32'sd100;

  // register index, taken from paddr[2]
  localparam logic REG_LOWER = 1'b0;
  localparam logic REG_UPPER = 1'b1;

  // request codes
  localparam logic ACT_ENQ = 1'b0;
  localparam logic ACT_DEQ = 1'b1;

  // queue index 0..2 maps to levels 1..3
  typedef logic [1:0] qidx_t;
  localparam qidx_t Q_HIGH = 2'd0;
  localparam qidx_t Q_MID  = 2'd1;
  localparam qidx_t Q_LOW  = 2'd2;

  localparam logic [1:0] LVL_NONE = 2'd0;

endpackage

>>> rtl/three_level_priority_queue.sv
// ----------------------------------------------------------------------------
// three_level_priority_queue
// Strict-priority queue with three FIFO levels sorted by two signed bounds.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_stall) carries one request: in_action 0
//   enqueues in_value, 1 dequeues the oldest entry of the highest non-empty
//   level. Every request gives exactly one result on the out_ channel.
//   Values above upper_bound go to level 1, below lower_bound to level 3,
//   others to level 2; bounds are written over the APB-style port
//   (lower_bound at 0x0, upper_bound at 0x4).
//   One request is taken every cycle while in_stall is low. out_valid is
//   set by the result register, in the cycle after acceptance; the registered
//   read port of the entry memory loads at the same edge and holds its value.
//   The result register parts the channels: a new request is accepted while
//   the current result is taken in the same cycle. When out_stall holds the
//   result, in_stall is raised until it is taken.
//   Reset empties all levels (counts and pointers cleared, no clearing pass
//   over the entry memory) and loads the bounds with 50 and 100.
// ----------------------------------------------------------------------------
module three_level_priority_queue #(
  parameter int LEVEL_DEPTH = tlpq_pkg::LEVEL_DEPTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // request channel
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic                                in_action,
  input  logic signed [tlpq_pkg::DATA_W-1:0]  in_value,
  // result channel
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [tlpq_pkg::DATA_W-1:0]  out_value,
  output logic [1:0]                          out_level,
  output logic                                out_was_empty,
  output logic                                out_was_dropped,
  output logic                                out_now_empty,
  // configuration port
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [tlpq_pkg::PADDR_W-1:0]        paddr,
  input  logic [tlpq_pkg::DATA_W-1:0]         pwdata,
  output logic [tlpq_pkg::DATA_W-1:0]         prdata,
  output logic                                pready
);
  import tlpq_pkg::*;

  localparam int SLOT_W = $clog2(LEVEL_DEPTH);
  localparam int FILL_W = $clog2(LEVEL_DEPTH + 1);
  localparam int MEM_D  = NUM_LEVELS * LEVEL_DEPTH;
  localparam int ADDR_W = $clog2(MEM_D);

  // configuration
  logic signed [DATA_W-1:0] lower_bound_r;
  logic signed [DATA_W-1:0] upper_bound_r;
  logic                     cfg_wr;

  // queue control state
  logic [FILL_W-1:0] fill_r    [NUM_LEVELS];
  logic [FILL_W-1:0] fill_nxt  [NUM_LEVELS];
  logic [SLOT_W-1:0] rd_slot_r [NUM_LEVELS];
  logic [SLOT_W-1:0] rd_slot_nxt [NUM_LEVELS];
  logic [SLOT_W-1:0] wr_slot_r [NUM_LEVELS];
  logic [SLOT_W-1:0] wr_slot_nxt [NUM_LEVELS];

  // entry memory
  logic [DATA_W-1:0] mem [MEM_D];
  logic [DATA_W-1:0] rd_data_r;

  // result register
  logic        out_valid_r;
  logic        has_value_r;
  logic [1:0]  level_r;
  logic        was_empty_r;
  logic        was_dropped_r;
  logic        now_empty_r;

  logic              accept;
  qidx_t             q_enq;
  qidx_t             q_deq;
  qidx_t             q_sel;
  logic              all_empty;
  logic              lvl_full;
  logic              do_write;
  logic              do_read;
  logic [SLOT_W-1:0] slot;
  logic [SLOT_W-1:0] slot_inc;
  logic [ADDR_W-1:0] addr;
  logic              now_empty;

  // ---------------- configuration port ----------------
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_UPPER) ? upper_bound_r : lower_bound_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lower_bound_r <= LOWER_RESET;
      upper_bound_r <= UPPER_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_UPPER) begin
        upper_bound_r <= pwdata;
      end else begin
        lower_bound_r <= pwdata;
      end
    end
  end

  // ---------------- request decode ----------------
  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    // below-lower test wins when the bounds cross
    priority if (in_value < lower_bound_r) begin
      q_enq = Q_LOW;
    end else if (upper_bound_r < in_value) begin
      q_enq = Q_HIGH;
    end else begin
      q_enq = Q_MID;
    end

    all_empty = 1'b0;
    priority if (fill_r[Q_HIGH] != '0) begin
      q_deq = Q_HIGH;
    end else if (fill_r[Q_MID] != '0) begin
      q_deq = Q_MID;
    end else if (fill_r[Q_LOW] != '0) begin
      q_deq = Q_LOW;
    end else begin
      q_deq     = Q_HIGH;
      all_empty = 1'b1;
    end

    q_sel    = (in_action == ACT_DEQ) ? q_deq : q_enq;
    lvl_full = (fill_r[q_sel] >= FILL_W'(LEVEL_DEPTH));
    do_write = accept && (in_action == ACT_ENQ) && !lvl_full;
    do_read  = accept && (in_action == ACT_DEQ) && !all_empty;

    slot     = (in_action == ACT_DEQ) ? rd_slot_r[q_sel] : wr_slot_r[q_sel];
    slot_inc = (slot == SLOT_W'(LEVEL_DEPTH - 1)) ? '0 : slot + SLOT_W'(1);
    addr     = ADDR_W'(ADDR_W'(q_sel) * ADDR_W'(LEVEL_DEPTH)) + ADDR_W'(slot);

    for (int i = 0; i < NUM_LEVELS; i++) begin
      fill_nxt[i]    = fill_r[i];
      rd_slot_nxt[i] = rd_slot_r[i];
      wr_slot_nxt[i] = wr_slot_r[i];
    end
    if (do_write) begin
      fill_nxt[q_sel]    = fill_r[q_sel] + FILL_W'(1);
      wr_slot_nxt[q_sel] = slot_inc;
    end
    if (do_read) begin
      fill_nxt[q_sel]    = fill_r[q_sel] - FILL_W'(1);
      rd_slot_nxt[q_sel] = slot_inc;
    end

    now_empty = 1'b1;
    for (int i = 0; i < NUM_LEVELS; i++) begin
      if (fill_nxt[i] != '0) begin
        now_empty = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        fill_r[i]    <= '0;
        rd_slot_r[i] <= '0;
        wr_slot_r[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NUM_LEVELS; i++) begin
        fill_r[i]    <= fill_nxt[i];
        rd_slot_r[i] <= rd_slot_nxt[i];
        wr_slot_r[i] <= wr_slot_nxt[i];
      end
    end
  end

  // ---------------- entry memory ----------------
  // writes and reads never meet in one cycle: a request is one or the other
  always_ff @(posedge clk) begin
    if (do_write) begin
      mem[addr] <= in_value;
    end
    if (do_read) begin
      rd_data_r <= mem[addr];
    end
  end

  // ---------------- result register ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      has_value_r   <= do_read;
      was_empty_r   <= (in_action == ACT_DEQ) && all_empty;
      was_dropped_r <= (in_action == ACT_ENQ) && lvl_full;
      now_empty_r   <= now_empty;
      if ((in_action == ACT_DEQ) && all_empty) begin
        level_r <= LVL_NONE;
      end else begin
        level_r <= q_sel + 2'd1;
      end
    end
  end

  assign out_valid       = out_valid_r;
  assign out_value       = has_value_r ? rd_data_r : '0;
  assign out_level       = level_r;
  assign out_was_empty   = was_empty_r;
  assign out_was_dropped = was_dropped_r;
  assign out_now_empty   = now_empty_r;

endmodule

>>> tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the three-level priority queue. Enqueue and
// dequeue requests are driven with random sender and receiver gaps. Each
// accepted request runs through a behavioral copy of the three level FIFOs,
// and each result is compared field by field against that prediction.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tlpq_pkg::*;

  localparam int Q_DEPTH     = LEVEL_DEPTH_DEF;
  localparam int CYCLE_LIMIT = 200000;
  localparam logic signed [DATA_W-1:0] INT_MIN = 32'sh8000_0000;
  localparam logic signed [DATA_W-1:0] INT_MAX = 32'sh7fff_ffff;

  typedef struct packed {
    logic signed [DATA_W-1:0] value;
    logic [1:0]               level;
    logic                     was_empty;
    logic                     was_dropped;
    logic                     now_empty;
  } queue_result_t;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  logic                     in_action;
  logic signed [DATA_W-1:0] in_value;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [DATA_W-1:0] out_value;
  logic [1:0]               out_level;
  logic                     out_was_empty;
  logic                     out_was_dropped;
  logic                     out_now_empty;
  logic                     psel;
  logic                     penable;
  logic                     pwrite;
  logic [PADDR_W-1:0]       paddr;
  logic [DATA_W-1:0]        pwdata;
  logic [DATA_W-1:0]        prdata;
  logic                     pready;

  // queue mirror
  logic signed [DATA_W-1:0] lo_bound = LOWER_RESET;
  logic signed [DATA_W-1:0] hi_bound = UPPER_RESET;
  logic signed [DATA_W-1:0] lvl_mem [NUM_LEVELS][Q_DEPTH];
  int                       head_idx [NUM_LEVELS];
  int                       tail_idx [NUM_LEVELS];
  int                       lvl_count [NUM_LEVELS];

  queue_result_t pending_results [$];
  int            errors = 0;
  int            cycle_count = 0;
  int            send_idle_pct;
  int            recv_idle_pct;

  three_level_priority_queue uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_action       (in_action),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_value       (out_value),
    .out_level       (out_level),
    .out_was_empty   (out_was_empty),
    .out_was_dropped (out_was_dropped),
    .out_now_empty   (out_now_empty),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  function automatic void reset_queue_mirror();
    for (int q = 0; q < NUM_LEVELS; q++) begin
      head_idx[q]  = 0;
      tail_idx[q]  = 0;
      lvl_count[q] = 0;
    end
  endfunction

  function automatic queue_result_t predict_queue_op(logic act, logic signed [DATA_W-1:0] val);
    queue_result_t r;
    int q;
    r = '0;
    if (act == ACT_ENQ) begin
      // below-lower wins when the bounds are crossed
      if (val < lo_bound)
        q = Q_LOW;
      else if (val > hi_bound)
        q = Q_HIGH;
      else
        q = Q_MID;
      r.level = 2'(q + 1);
      if (lvl_count[q] >= Q_DEPTH) begin
        r.was_dropped = 1'b1;
      end else begin
        lvl_mem[q][tail_idx[q]] = val;
        tail_idx[q] = (tail_idx[q] + 1) % Q_DEPTH;
        lvl_count[q]++;
      end
    end else begin
      q = NUM_LEVELS;
      for (int i = NUM_LEVELS - 1; i >= 0; i--)
        if (lvl_count[i] != 0) q = i;
      if (q == NUM_LEVELS) begin
        r.was_empty = 1'b1;
        r.level     = LVL_NONE;
      end else begin
        r.value = lvl_mem[q][head_idx[q]];
        r.level = 2'(q + 1);
        head_idx[q] = (head_idx[q] + 1) % Q_DEPTH;
        lvl_count[q]--;
      end
    end
    r.now_empty = (lvl_count[0] == 0) && (lvl_count[1] == 0) && (lvl_count[2] == 0);
    return r;
  endfunction

  task automatic check_field(string name, logic signed [DATA_W-1:0] want,
                             logic signed [DATA_W-1:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  // results are checked before the new request is predicted, both on one edge
  always @(posedge clk) begin
    queue_result_t want;
    if (!rst_n) begin
      reset_queue_mirror();
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result with no request pending, expected none, got value %0d level %0d",
                   $time, out_value, out_level);
          errors++;
        end else begin
          want = pending_results.pop_front();
          check_field("out_value", want.value, out_value);
          check_field("out_level", DATA_W'(want.level), DATA_W'(out_level));
          check_field("out_was_empty", DATA_W'(want.was_empty), DATA_W'(out_was_empty));
          check_field("out_was_dropped", DATA_W'(want.was_dropped),
                      DATA_W'(out_was_dropped));
          check_field("out_now_empty", DATA_W'(want.now_empty), DATA_W'(out_now_empty));
        end
      end
      if (in_valid && !in_stall)
        pending_results.push_back(predict_queue_op(in_action, in_value));
    end
  end

  // called and returns at a falling edge
  task automatic send_request(logic act, logic signed [DATA_W-1:0] val);
    int gap;
    gap = 0;
    while ($urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_action <= act;
    in_value  <= val;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  task automatic wait_for_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_bound(logic reg_sel, logic signed [DATA_W-1:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_LOWER)
      lo_bound = val;
    else
      hi_bound = val;
  endtask

  function automatic logic signed [DATA_W-1:0] pick_value();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3:       return lo_bound + DATA_W'($urandom_range(2)) - 1;
      4:       return hi_bound + DATA_W'($urandom_range(2)) - 1;
      5: begin
        case ($urandom_range(3))
          0:       return INT_MIN;
          1:       return INT_MAX;
          2:       return '0;
          default: return '1;
        endcase
      end
      default: return DATA_W'($urandom_range(600)) - 300;
    endcase
  endfunction

  task automatic set_random_bounds();
    logic signed [DATA_W-1:0] a;
    logic signed [DATA_W-1:0] b;
    a = $urandom;
    b = $urandom;
    case ($urandom_range(5))
      0: begin
        write_bound(REG_LOWER, LOWER_RESET);
        write_bound(REG_UPPER, UPPER_RESET);
      end
      1: begin
        write_bound(REG_LOWER, INT_MIN);
        write_bound(REG_UPPER, INT_MAX);
      end
      2: begin
        write_bound(REG_LOWER, INT_MAX);
        write_bound(REG_UPPER, INT_MIN);
      end
      3: begin
        write_bound(REG_LOWER, (a < b) ? a : b);
        write_bound(REG_UPPER, (a < b) ? b : a);
      end
      4: begin
        write_bound(REG_UPPER, a);
        write_bound(REG_LOWER, b);
      end
      default: begin
        write_bound(REG_LOWER, -DATA_W'($urandom_range(150)));
        write_bound(REG_UPPER, DATA_W'($urandom_range(150)));
      end
    endcase
  endtask

  task automatic test_default_bounds();
    send_request(ACT_DEQ, '0);
    send_request(ACT_ENQ, 32'sd50);
    send_request(ACT_ENQ, 32'sd100);
    send_request(ACT_ENQ, 32'sd101);
    send_request(ACT_ENQ, 32'sd49);
    send_request(ACT_ENQ, INT_MAX);
    send_request(ACT_ENQ, INT_MIN);
    repeat (6) send_request(ACT_DEQ, $urandom);
    send_request(ACT_DEQ, '1);
    wait_for_results();
  endtask

  task automatic test_crossed_bounds();
    write_bound(REG_LOWER, 32'sd100);
    write_bound(REG_UPPER, 32'sd50);
    // 75 lies below lower and above upper at once
    send_request(ACT_ENQ, 32'sd75);
    send_request(ACT_ENQ, 32'sd120);
    send_request(ACT_ENQ, 32'sd30);
    send_request(ACT_ENQ, 32'sd100);
    send_request(ACT_ENQ, 32'sd50);
    repeat (5) send_request(ACT_DEQ, '0);
    wait_for_results();
  endtask

  task automatic test_full_level();
    write_bound(REG_LOWER, INT_MIN);
    write_bound(REG_UPPER, INT_MAX);
    // every value lands in the middle level, the last one overflows it
    repeat (Q_DEPTH + 1) send_request(ACT_ENQ, $urandom);
    send_request(ACT_DEQ, '0);
    wait_for_results();
  endtask

  task automatic test_random_traffic(int n_items, int s_pct, int r_pct);
    int done;
    int burst;
    int enq_pct;
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    done = 0;
    while (done < n_items) begin
      // hold off until the queue has answered everything, then retune bounds
      wait_for_results();
      set_random_bounds();
      case ($urandom_range(3))
        0:       enq_pct = 30;
        1:       enq_pct = 50;
        2:       enq_pct = 70;
        default: enq_pct = 90;
      endcase
      burst = $urandom_range(30, 70);
      for (int k = 0; k < burst && done < n_items; k++) begin
        send_request(($urandom_range(99) < enq_pct) ? ACT_ENQ : ACT_DEQ, pick_value());
        done++;
      end
    end
    wait_for_results();
  endtask

  initial begin
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_action   = ACT_ENQ;
    in_value    = '0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    send_idle_pct = 16;
    recv_idle_pct = 63;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_default_bounds();
    test_crossed_bounds();
    test_full_level();
    test_random_traffic(400, 16, 63);
    test_random_traffic(400, 63, 16);
    test_random_traffic(400, 0, 0);

    repeat (4) @(negedge clk);
    if (errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule
